>>> rtl/b64lw_pkg.sv
// ----------------------------------------------------------------------------
// b64lw_pkg
// Shared types, constants and the character map of the base64 line encoder.
// ----------------------------------------------------------------------------
package b64lw_pkg;

  localparam logic [7:0] PAD_CHAR        = 8'h3D;
  localparam logic [7:0] LINE_LEN_RESET  = 8'd76;
  localparam int         JOB_CHARS       = 4;

  // Register map (byte address / 4)
  localparam logic [0:0] REG_LINE_LENGTH = 1'b0;

  // Byte position within the current 3-byte group
  typedef enum logic [1:0] {
    PH_ZERO = 2'd0,
    PH_ONE  = 2'd1,
    PH_TWO  = 2'd2
  } phase_t;

  // All characters caused by one input byte
  typedef struct packed {
    logic [JOB_CHARS-1:0][7:0] chars;
    logic [1:0]                last_idx;  // number of chars minus one
    logic                      fin;       // last char ends the message
  } job_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] ext;
    logic [7:0] r;
    ext = {2'b00, v};
    if (v < 6'd26) begin
      r = ext + 8'h41;
    end else if (v < 6'd52) begin
      r = ext + 8'd71;
    end else if (v < 6'd62) begin
      r = ext - 8'd4;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

endpackage

>>> rtl/b64lw_chan_if.sv
// ----------------------------------------------------------------------------
// b64lw channel interfaces
// Valid/ready channels for plain bytes in and encoded characters out.
// ----------------------------------------------------------------------------
interface b64lw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64lw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       line_end;
  logic       message_end;
  logic       run_last;

  modport source (output valid, output out_char, output line_end,
                  output message_end, output run_last, input ready);
  modport sink   (input valid, input out_char, input line_end,
                  input message_end, input run_last, output ready);
endinterface

>>> rtl/base64_encoder_line_wrap_core.sv
// ----------------------------------------------------------------------------
// base64_encoder_line_wrap_core
// Streaming base64 encoder with '=' padding and line-end marking.
// ----------------------------------------------------------------------------
//  channel | dir | handshake      | payload
//  in_ch   | in  | valid/ready    | data_byte[7:0], final_byte
//  out_ch  | out | valid/ready    | out_char[7:0], line_end, message_end, run_last
//  cfg     | in  | APB psel/pen.. | reg 0 @ 0x0: line_length[7:0] (reset 76)
//
//  A byte is taken in the cycle it shows up while the job queue has room.
//  The single-char output register lets the back end send one char per cycle
//  unless out_ch stalls; a byte yields 1 or 2 chars, 2 to 4 on a final byte.
//  Output stalls fill the queue (QUEUE_DEPTH jobs) before in_ch.ready drops.
//  Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module base64_encoder_line_wrap_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  b64lw_in_if.sink    in_ch,
  b64lw_out_if.source out_ch,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // line length register
  logic [7:0] line_len_r, line_len_nxt;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == b64lw_pkg::REG_LINE_LENGTH);

  always_comb begin
    line_len_nxt = line_len_r;
    if (cfg_wr) begin
      line_len_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r <= b64lw_pkg::LINE_LEN_RESET;
    end else begin
      line_len_r <= line_len_nxt;
    end
  end

  assign prdata = (paddr == b64lw_pkg::REG_LINE_LENGTH) ? {24'd0, line_len_r} : 32'd0;

  // front: group phase + leftover bits -> one job per byte
  logic            push_valid, push_ready;
  b64lw_pkg::job_t push_job;
  logic            pop_valid, pop_ready;
  b64lw_pkg::job_t pop_job;

  b64lw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  // decouples byte intake from char output
  b64lw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job),
    .pop_ready  (pop_ready)
  );

  // back: line column, line/message end flags, output register
  b64lw_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .line_length (line_len_r),
    .pop_valid   (pop_valid),
    .pop_job     (pop_job),
    .pop_ready   (pop_ready),
    .out_ch      (out_ch)
  );

endmodule

>>> rtl/b64lw_front.sv
// ----------------------------------------------------------------------------
// b64lw_front
// Takes plain bytes, tracks group phase and leftover bits, builds char jobs.
// ----------------------------------------------------------------------------
module b64lw_front (
  input  logic               clk,
  input  logic               rst_n,
  b64lw_in_if.sink           in_ch,
  output logic               push_valid,
  output b64lw_pkg::job_t    push_job,
  input  logic               push_ready
);

  b64lw_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]        left_r, left_nxt;
  logic              accept;
  logic [7:0]        b;
  logic              fin;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign accept      = in_ch.valid & push_ready;
  assign b           = in_ch.data_byte;
  assign fin         = in_ch.final_byte;

  // next group state
  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    if (accept) begin
      case (phase_r)
        b64lw_pkg::PH_ONE: begin
          phase_nxt = fin ? b64lw_pkg::PH_ZERO : b64lw_pkg::PH_TWO;
          left_nxt  = fin ? 4'd0 : b[3:0];
        end
        b64lw_pkg::PH_TWO: begin
          phase_nxt = b64lw_pkg::PH_ZERO;
          left_nxt  = 4'd0;
        end
        default: begin
          phase_nxt = fin ? b64lw_pkg::PH_ZERO : b64lw_pkg::PH_ONE;
          left_nxt  = fin ? 4'd0 : {2'b00, b[1:0]};
        end
      endcase
    end
  end

  // job contents
  always_comb begin
    push_job          = '0;
    push_job.fin      = fin;
    push_job.chars[2] = b64lw_pkg::PAD_CHAR;
    push_job.chars[3] = b64lw_pkg::PAD_CHAR;
    case (phase_r)
      b64lw_pkg::PH_ONE: begin
        push_job.chars[0] = b64lw_pkg::sextet_char({left_r[1:0], b[7:4]});
        push_job.chars[1] = b64lw_pkg::sextet_char({b[3:0], 2'b00});
        push_job.last_idx = fin ? 2'd2 : 2'd0;
      end
      b64lw_pkg::PH_TWO: begin
        push_job.chars[0] = b64lw_pkg::sextet_char({left_r, b[7:6]});
        push_job.chars[1] = b64lw_pkg::sextet_char(b[5:0]);
        push_job.last_idx = 2'd1;
      end
      default: begin
        push_job.chars[0] = b64lw_pkg::sextet_char(b[7:2]);
        push_job.chars[1] = b64lw_pkg::sextet_char({b[1:0], 4'b0000});
        push_job.last_idx = fin ? 2'd3 : 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= b64lw_pkg::PH_ZERO;
      left_r  <= 4'd0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

>>> rtl/b64lw_queue.sv
// ----------------------------------------------------------------------------
// b64lw_queue
// Small register FIFO of char jobs between front and back.
// ----------------------------------------------------------------------------
module b64lw_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  b64lw_pkg::job_t push_job,
  output logic            push_ready,
  output logic            pop_valid,
  output b64lw_pkg::job_t pop_job,
  input  logic            pop_ready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64lw_pkg::job_t mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> rtl/b64lw_back.sv
// ----------------------------------------------------------------------------
// b64lw_back
// Walks each job a char a cycle unless stalled; tracks column, drives output.
// ----------------------------------------------------------------------------
module b64lw_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [7:0]      line_length,
  input  logic            pop_valid,
  input  b64lw_pkg::job_t pop_job,
  output logic            pop_ready,
  b64lw_out_if.source     out_ch
);

  logic [1:0] idx_r, idx_nxt;
  logic [7:0] col_r, col_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic [7:0] char_r, char_nxt;
  logic       le_r, le_nxt;
  logic       me_r, me_nxt;
  logic       rl_r, rl_nxt;

  logic       load;
  logic       emit;
  logic       is_last;
  logic       is_end;
  logic [8:0] col_inc;
  logic [8:0] limit;
  logic       wrap;

  assign load    = !ovalid_r || out_ch.ready;
  assign emit    = load && pop_valid;
  assign is_last = (idx_r == pop_job.last_idx);
  assign is_end  = is_last && pop_job.fin;
  assign pop_ready = load && is_last;

  // zero line length means 256 chars per line
  assign col_inc = {1'b0, col_r} + 9'd1;
  assign limit   = (line_length == 8'd0) ? 9'd256 : {1'b0, line_length};
  assign wrap    = (col_inc >= limit);

  always_comb begin
    idx_nxt    = idx_r;
    col_nxt    = col_r;
    ovalid_nxt = ovalid_r;
    char_nxt   = char_r;
    le_nxt     = le_r;
    me_nxt     = me_r;
    rl_nxt     = rl_r;
    if (load) begin
      ovalid_nxt = pop_valid;
    end
    if (emit) begin
      char_nxt = pop_job.chars[idx_r];
      le_nxt   = wrap || is_end;
      me_nxt   = is_end;
      rl_nxt   = is_last;
      col_nxt  = (wrap || is_end) ? 8'd0 : col_inc[7:0];
      idx_nxt  = is_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= 2'd0;
      col_r    <= 8'd0;
      ovalid_r <= 1'b0;
    end else begin
      idx_r    <= idx_nxt;
      col_r    <= col_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    le_r   <= le_nxt;
    me_r   <= me_nxt;
    rl_r   <= rl_nxt;
  end

  assign out_ch.valid       = ovalid_r;
  assign out_ch.out_char    = char_r;
  assign out_ch.line_end    = le_r;
  assign out_ch.message_end = me_r;
  assign out_ch.run_last    = rl_r;

endmodule
